### design/ufrt_pkg.sv
// ----------------------------------------------------------------------------
// ufrt_pkg: shared types and constants of the frame reassembly tracker
// Field widths, default parameter values and the types that pass between
// the front, the queue and the back.
// ----------------------------------------------------------------------------
`default_nettype none

package ufrt_pkg;

  localparam int FRAME_ID_W     = 8;
  localparam int PKT_INDEX_W    = 8;
  localparam int OFFSET_W       = 19;
  localparam int COUNT_W        = 9;
  localparam int STAT_W         = 2;
  localparam int PROD_W         = 32;

  localparam int PAYLOAD_BYTES_DEF = 1444;
  localparam int STALE_WINDOW_DEF  = 3;

  // slot count saturates here
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // frame id step that retires the older slot
  localparam logic [FRAME_ID_W-1:0] RETIRE_STEP = 8'd2;

  // statistics codes
  localparam logic [STAT_W-1:0] STAT_NONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ONE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TWO  = 2'd2;

  // decoded packet header held in the queue
  typedef struct packed {
    logic [FRAME_ID_W-1:0]  frame_id;
    logic                   screen_sel;
    logic                   last_packet;
    logic [PKT_INDEX_W-1:0] packet_index;
    logic [OFFSET_W-1:0]    write_offset;
  } q_entry_t;

  // queue status seen by its neighbors
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

endpackage

`default_nettype wire

### design/udp_frame_reassembly_tracker_unit.sv
// ----------------------------------------------------------------------------
// udp_frame_reassembly_tracker_unit: two-screen frame reassembly tracker
// Takes one packet header per transfer and returns one placement and
// frame-completion result per header.
// ----------------------------------------------------------------------------
// Path from header transfer to result valid: intake register at the transfer
// edge, queue entry, then state update into the result register.
// Throughput: one header per cycle while out_stall stays low; the per-screen
// state update is a single read-modify-write in the back stage.
// Reset: synchronous rst clears tracked ids, slot state and all valids.
`default_nettype none

module udp_frame_reassembly_tracker_unit #(
  parameter int PAYLOAD_BYTES = ufrt_pkg::PAYLOAD_BYTES_DEF,
  parameter int STALE_WINDOW  = ufrt_pkg::STALE_WINDOW_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ufrt_pkg::FRAME_ID_W-1:0]   frame_id,
  input  wire logic                              screen_sel,
  input  wire logic                              last_packet,
  input  wire logic [ufrt_pkg::PKT_INDEX_W-1:0]  packet_index,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   write_enable,
  output logic                                   write_slot,
  output logic [ufrt_pkg::OFFSET_W-1:0]          write_offset,
  output logic                                   frame_ready,
  output logic [ufrt_pkg::COUNT_W-1:0]           ready_packets,
  output logic [ufrt_pkg::STAT_W-1:0]            frames_retired,
  output logic [ufrt_pkg::STAT_W-1:0]            frames_dropped
);
  import ufrt_pkg::*;

  q_status_t q_status;
  q_entry_t  push_entry;
  q_entry_t  head;
  logic      push;
  logic      pop;

  // intake and offset computation
  ufrt_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frame_id     (frame_id),
    .screen_sel   (screen_sel),
    .last_packet  (last_packet),
    .packet_index (packet_index),
    .q_status     (q_status),
    .push         (push),
    .push_entry   (push_entry)
  );

  // decoupling queue
  ufrt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // tracker state and results
  ufrt_back #(
    .STALE_WINDOW (STALE_WINDOW)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .write_enable   (write_enable),
    .write_slot     (write_slot),
    .write_offset   (write_offset),
    .frame_ready    (frame_ready),
    .ready_packets  (ready_packets),
    .frames_retired (frames_retired),
    .frames_dropped (frames_dropped)
  );

endmodule

`default_nettype wire

### design/ufrt_front.sv
// ----------------------------------------------------------------------------
// ufrt_front: header intake stage
// Registers the incoming header, computes the payload byte offset and
// pushes the decoded entry into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ufrt_front #(
  parameter int PAYLOAD_BYTES = ufrt_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [ufrt_pkg::FRAME_ID_W-1:0]     frame_id,
  input  wire logic                                screen_sel,
  input  wire logic                                last_packet,
  input  wire logic [ufrt_pkg::PKT_INDEX_W-1:0]    packet_index,
  input  wire ufrt_pkg::q_status_t                 q_status,
  output logic                                     push,
  output ufrt_pkg::q_entry_t                       push_entry
);
  import ufrt_pkg::*;

  logic                 front_valid;
  logic                 front_valid_next;
  q_entry_t             entry;
  logic                 take;
  logic [PROD_W-1:0]    prod;

  // stall only while the held entry cannot move on
  assign in_stall = front_valid & q_status.full;
  assign take     = in_valid & ~in_stall;
  assign push     = front_valid & ~q_status.full;
  assign push_entry = entry;

  // byte offset of the payload, kept to the field width
  assign prod = PROD_W'(packet_index) * PROD_W'(PAYLOAD_BYTES);

  always_comb begin
    front_valid_next = front_valid;
    if (take) begin
      front_valid_next = 1'b1;
    end else if (push) begin
      front_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= front_valid_next;
    end
  end

  // header register
  always_ff @(posedge clk) begin
    if (take) begin
      entry.frame_id     <= frame_id;
      entry.screen_sel   <= screen_sel;
      entry.last_packet  <= last_packet;
      entry.packet_index <= packet_index;
      entry.write_offset <= prod[OFFSET_W-1:0];
    end
  end

endmodule

`default_nettype wire

### design/ufrt_queue.sv
// ----------------------------------------------------------------------------
// ufrt_queue: two-entry queue between front and back
// Lets the intake and the tracker stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module ufrt_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire ufrt_pkg::q_entry_t  push_entry,
  input  wire logic                pop,
  output ufrt_pkg::q_entry_t       head,
  output ufrt_pkg::q_status_t      status
);
  import ufrt_pkg::*;

  localparam int DEPTH = 2;

  q_entry_t     entries [DEPTH];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic [1:0]   count_next;

  assign head            = entries[rd_ptr];
  assign status.full     = (count == 2'(DEPTH));
  assign status.nonempty = (count != 2'd0);

  // occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !(push && !pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> status.nonempty)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

### design/ufrt_back.sv
// ----------------------------------------------------------------------------
// ufrt_back: per-screen reassembly state and result register
// Sequences the frame id of each header against the tracked id, updates
// the two slots of that screen and registers one result per header.
// ----------------------------------------------------------------------------
`default_nettype none

module ufrt_back #(
  parameter int STALE_WINDOW = ufrt_pkg::STALE_WINDOW_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ufrt_pkg::q_entry_t                head,
  input  wire ufrt_pkg::q_status_t               q_status,
  output logic                                   pop,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   write_enable,
  output logic                                   write_slot,
  output logic [ufrt_pkg::OFFSET_W-1:0]          write_offset,
  output logic                                   frame_ready,
  output logic [ufrt_pkg::COUNT_W-1:0]           ready_packets,
  output logic [ufrt_pkg::STAT_W-1:0]            frames_retired,
  output logic [ufrt_pkg::STAT_W-1:0]            frames_dropped
);
  import ufrt_pkg::*;

  localparam logic [FRAME_ID_W-1:0] STALE_LIMIT = FRAME_ID_W'(STALE_WINDOW);

  // tracker state, slot index is {screen, slot}
  logic [FRAME_ID_W-1:0] tracked_id [2];
  logic                  newest_slot [2];
  logic [COUNT_W-1:0]    slot_count [4];
  logic [COUNT_W-1:0]    slot_target [4];
  logic                  slot_known [4];
  logic                  slot_done [4];

  logic                  scr;
  logic [FRAME_ID_W-1:0] tid;
  logic                  ns;
  logic [FRAME_ID_W-1:0] diff;
  logic [FRAME_ID_W-1:0] lag;
  logic [FRAME_ID_W-1:0] tid_next;
  logic                  ns_next;
  logic [1:0]            clr;
  logic                  ignore;
  logic                  slot;
  logic                  ready;
  logic [STAT_W-1:0]     retired;
  logic [STAT_W-1:0]     dropped;
  logic [COUNT_W-1:0]    cnt_next [2];
  logic [COUNT_W-1:0]    tgt_next [2];
  logic                  known_next [2];
  logic                  done_next [2];
  logic [COUNT_W-1:0]    new_target;
  logic                  out_valid_next;

  // take a header when the result register is free or draining
  assign pop = q_status.nonempty & (~out_valid | ~out_stall);

  // sequence the frame id against the tracked id
  always_comb begin
    scr      = head.screen_sel;
    tid      = tracked_id[scr];
    ns       = newest_slot[scr];
    diff     = head.frame_id - tid;
    lag      = tid - head.frame_id;
    tid_next = tid;
    ns_next  = ns;
    clr      = 2'b00;
    ignore   = 1'b0;
    retired  = STAT_NONE;
    dropped  = STAT_NONE;
    if (diff == RETIRE_STEP) begin
      // retire the older slot and flip
      retired       = STAT_ONE;
      dropped       = slot_done[{scr, ~ns}] ? STAT_NONE : STAT_ONE;
      ns_next       = ~ns;
      clr[~ns]      = 1'b1;
      tid_next      = tid + FRAME_ID_W'(1);
    end else if (diff > RETIRE_STEP) begin
      if (lag <= STALE_LIMIT) begin
        ignore = 1'b1;
      end else begin
        // resync on a jump: drop both slots
        retired  = STAT_TWO;
        dropped  = STAT_TWO;
        ns_next  = 1'b0;
        clr      = 2'b11;
        tid_next = head.frame_id;
      end
    end
    slot = (head.frame_id == tid_next) ? ~ns_next : ns_next;
  end

  // slot update for the selected screen
  always_comb begin
    new_target = COUNT_W'(head.packet_index) + COUNT_W'(1);
    for (int j = 0; j < 2; j++) begin
      cnt_next[j]   = clr[j] ? '0 : slot_count[{scr, j[0]}];
      tgt_next[j]   = clr[j] ? '0 : slot_target[{scr, j[0]}];
      known_next[j] = clr[j] ? 1'b0 : slot_known[{scr, j[0]}];
      done_next[j]  = clr[j] ? 1'b0 : slot_done[{scr, j[0]}];
      if (slot == j[0]) begin
        if (head.last_packet) begin
          tgt_next[j]   = new_target;
          known_next[j] = 1'b1;
        end
        if (cnt_next[j] < COUNT_MAX) begin
          cnt_next[j] = cnt_next[j] + COUNT_W'(1);
        end
      end
    end
    ready = known_next[slot] & (cnt_next[slot] >= tgt_next[slot]);
    if (ready) begin
      done_next[slot] = 1'b1;
    end
  end

  // state write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 2; s++) begin
        tracked_id[s]  <= '0;
        newest_slot[s] <= 1'b0;
      end
      for (int k = 0; k < 4; k++) begin
        slot_count[k]  <= '0;
        slot_target[k] <= '0;
        slot_known[k]  <= 1'b0;
        slot_done[k]   <= 1'b0;
      end
    end else if (pop && !ignore) begin
      tracked_id[scr]  <= tid_next;
      newest_slot[scr] <= ns_next;
      for (int j = 0; j < 2; j++) begin
        slot_count[{scr, j[0]}]  <= cnt_next[j];
        slot_target[{scr, j[0]}] <= tgt_next[j];
        slot_known[{scr, j[0]}]  <= known_next[j];
        slot_done[{scr, j[0]}]   <= done_next[j];
      end
    end
  end

  // result register valid
  always_comb begin
    out_valid_next = out_valid;
    if (pop) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // result payload, all zero for an ignored header
  always_ff @(posedge clk) begin
    if (pop) begin
      write_enable   <= ~ignore;
      write_slot     <= ignore ? 1'b0 : slot;
      write_offset   <= ignore ? '0 : head.write_offset;
      frame_ready    <= ~ignore & ready;
      ready_packets  <= (~ignore & ready) ? tgt_next[slot] : '0;
      frames_retired <= ignore ? STAT_NONE : retired;
      frames_dropped <= ignore ? STAT_NONE : dropped;
    end
  end

  a_ignored_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |-> (!frame_ready && frames_retired == STAT_NONE
                                      && frames_dropped == STAT_NONE))
    else $error("ignored header reports activity");

  a_dropped_le_retired: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frames_dropped <= frames_retired))
    else $error("more frames dropped than retired");

  a_ready_has_target: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_ready) |-> (ready_packets != '0))
    else $error("frame ready with empty target");

endmodule

`default_nettype wire

### verif/ufrt_placement_checker.sv
// ----------------------------------------------------------------------------
// ufrt_placement_checker: result checker for the frame reassembly tracker
// Watches both channels of the tracker. Every accepted header is run through
// a per-screen model of the tracked frame id and the two reassembly slots.
// The expected placement is queued, and each accepted result is compared
// field by field with the oldest queued placement.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ufrt_placement_checker #(
  parameter int PAYLOAD_BYTES = ufrt_pkg::PAYLOAD_BYTES_DEF,
  parameter int STALE_WINDOW  = ufrt_pkg::STALE_WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [ufrt_pkg::FRAME_ID_W-1:0]  frame_id,
  input  logic                             screen_sel,
  input  logic                             last_packet,
  input  logic [ufrt_pkg::PKT_INDEX_W-1:0] packet_index,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             write_enable,
  input  logic                             write_slot,
  input  logic [ufrt_pkg::OFFSET_W-1:0]    write_offset,
  input  logic                             frame_ready,
  input  logic [ufrt_pkg::COUNT_W-1:0]     ready_packets,
  input  logic [ufrt_pkg::STAT_W-1:0]      frames_retired,
  input  logic [ufrt_pkg::STAT_W-1:0]      frames_dropped,
  output int                               fail_count,
  output int                               results_owed
);
  import ufrt_pkg::*;

  // one placement result as the tracker reports it
  typedef struct packed {
    logic                write_enable;
    logic                write_slot;
    logic [OFFSET_W-1:0] write_offset;
    logic                frame_ready;
    logic [COUNT_W-1:0]  ready_packets;
    logic [STAT_W-1:0]   frames_retired;
    logic [STAT_W-1:0]   frames_dropped;
  } placement_t;

  // per-screen tracking state, slot index is {screen, slot}
  logic [FRAME_ID_W-1:0] trk_id    [2];
  logic                  newest    [2];
  logic [COUNT_W-1:0]    cnt       [4];
  logic [COUNT_W-1:0]    tgt       [4];
  logic                  tgt_known [4];
  logic                  done      [4];

  placement_t owed_placements[$];

  function automatic void wipe_slot(input int k);
    cnt[k]       = '0;
    tgt[k]       = '0;
    tgt_known[k] = 1'b0;
    done[k]      = 1'b0;
  endfunction

  // advance the screen state for one header and build its placement
  task automatic place_header(input logic [FRAME_ID_W-1:0] fid, input logic scr,
                              input logic lst, input logic [PKT_INDEX_W-1:0] pidx,
                              output placement_t r);
    logic [FRAME_ID_W-1:0] gap_fwd;
    logic [FRAME_ID_W-1:0] gap_back;
    logic                  older;
    logic                  slot;
    int                    k;
    int                    prod;
    r = '0;
    gap_fwd = fid - trk_id[scr];
    if (gap_fwd == RETIRE_STEP) begin
      // next frame arrived: retire the older slot and reuse it as newest
      older = ~newest[scr];
      k = {scr, older};
      r.frames_retired = STAT_ONE;
      r.frames_dropped = done[k] ? STAT_NONE : STAT_ONE;
      newest[scr] = older;
      wipe_slot(k);
      trk_id[scr] = trk_id[scr] + 1'b1;
    end else if (gap_fwd > RETIRE_STEP) begin
      gap_back = trk_id[scr] - fid;
      // late packet of an old frame: its placement stays all zero
      if (gap_back <= STALE_WINDOW) return;
      // resync on a jump in frame ids
      newest[scr] = 1'b0;
      wipe_slot({scr, 1'b0});
      wipe_slot({scr, 1'b1});
      r.frames_retired = STAT_TWO;
      r.frames_dropped = STAT_TWO;
      trk_id[scr] = fid;
    end

    slot = (fid == trk_id[scr]) ? ~newest[scr] : newest[scr];
    k = {scr, slot};
    if (lst) begin
      tgt[k]       = pidx + 9'd1;
      tgt_known[k] = 1'b1;
    end
    if (cnt[k] != COUNT_MAX) cnt[k] = cnt[k] + 1'b1;
    if (tgt_known[k] && cnt[k] >= tgt[k]) begin
      done[k]         = 1'b1;
      r.frame_ready   = 1'b1;
      r.ready_packets = tgt[k];
    end

    prod = pidx * PAYLOAD_BYTES;
    r.write_enable = 1'b1;
    r.write_slot   = slot;
    r.write_offset = prod[OFFSET_W-1:0];
  endtask

  function automatic int field_differs(input string what, input int want, input int got);
    if (want == got) return 0;
    $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    return 1;
  endfunction

  // compare results, then predict newly accepted headers
  always @(posedge clk) begin
    placement_t want;
    placement_t got;
    int         errs;
    errs = 0;
    if (rst) begin
      for (int s = 0; s < 2; s++) begin
        trk_id[s] = '0;
        newest[s] = 1'b0;
      end
      for (int k = 0; k < 4; k++) wipe_slot(k);
      owed_placements.delete();
      fail_count   <= 0;
      results_owed <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.write_enable   = write_enable;
        got.write_slot     = write_slot;
        got.write_offset   = write_offset;
        got.frame_ready    = frame_ready;
        got.ready_packets  = ready_packets;
        got.frames_retired = frames_retired;
        got.frames_dropped = frames_dropped;
        if (owed_placements.size() == 0) begin
          $display("%0t: result with no header pending, expected none actual %h",
                   $time, got);
          errs++;
        end else begin
          want = owed_placements.pop_front();
          errs += field_differs("write_enable", want.write_enable, got.write_enable);
          errs += field_differs("write_slot", want.write_slot, got.write_slot);
          errs += field_differs("write_offset", want.write_offset, got.write_offset);
          errs += field_differs("frame_ready", want.frame_ready, got.frame_ready);
          errs += field_differs("ready_packets", want.ready_packets, got.ready_packets);
          errs += field_differs("frames_retired", want.frames_retired, got.frames_retired);
          errs += field_differs("frames_dropped", want.frames_dropped, got.frames_dropped);
        end
      end
      if (in_valid && !in_stall) begin
        place_header(frame_id, screen_sel, last_packet, packet_index, want);
        owed_placements.push_back(want);
      end
      fail_count   <= fail_count + errs;
      results_owed <= owed_placements.size();
    end
  end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the frame reassembly tracker
// Drives packet headers with random gaps and random result-side stalls:
// a directed opener for retire, resync, stale and completion cases, then
// random frame streams on both screens, including lossy, duplicated,
// reordered and flooded frames. The checker beside the block does the
// prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import ufrt_pkg::*;

  localparam int HEADER_COUNT = 1300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int FLOOD_LEN    = 520;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [FRAME_ID_W-1:0]  frame_id = '0;
  logic                   screen_sel = 1'b0;
  logic                   last_packet = 1'b0;
  logic [PKT_INDEX_W-1:0] packet_index = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   write_enable;
  logic                   write_slot;
  logic [OFFSET_W-1:0]    write_offset;
  logic                   frame_ready;
  logic [COUNT_W-1:0]     ready_packets;
  logic [STAT_W-1:0]      frames_retired;
  logic [STAT_W-1:0]      frames_dropped;
  int                     fail_count;
  int                     results_owed;

  int                     cycles = 0;
  int                     tx_sent = 0;
  bit                     tx_steady = 1'b0;
  int                     stall_left = 0;
  bit                     rx_steady = 1'b0;

  always #5 clk = ~clk;

  udp_frame_reassembly_tracker_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .frame_id       (frame_id),
    .screen_sel     (screen_sel),
    .last_packet    (last_packet),
    .packet_index   (packet_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .write_enable   (write_enable),
    .write_slot     (write_slot),
    .write_offset   (write_offset),
    .frame_ready    (frame_ready),
    .ready_packets  (ready_packets),
    .frames_retired (frames_retired),
    .frames_dropped (frames_dropped)
  );

  ufrt_placement_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .frame_id       (frame_id),
    .screen_sel     (screen_sel),
    .last_packet    (last_packet),
    .packet_index   (packet_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .write_enable   (write_enable),
    .write_slot     (write_slot),
    .write_offset   (write_offset),
    .frame_ready    (frame_ready),
    .ready_packets  (ready_packets),
    .frames_retired (frames_retired),
    .frames_dropped (frames_dropped),
    .fail_count     (fail_count),
    .results_owed   (results_owed)
  );

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("udp_frame_reassembly_tracker_unit: mismatch");
      $finish;
    end
  end

  // result side: draw a stall length after every transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      stall_left = rx_steady ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 99) == 0) rx_steady = !rx_steady;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one header transfer after a random gap
  task automatic send_header(input logic [FRAME_ID_W-1:0] fid, input logic scr,
                             input logic lst, input logic [PKT_INDEX_W-1:0] pidx);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    frame_id     <= fid;
    screen_sel   <= scr;
    last_packet  <= lst;
    packet_index <= pidx;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    tx_sent++;
    if ($urandom_range(0, 99) == 0) tx_steady = !tx_steady;
  endtask

  // all packets of one frame, optionally shuffled, lossy or with repeats
  task automatic send_frame(input logic scr, input logic [FRAME_ID_W-1:0] fid,
                            input int n, input bit lossy, input bit dup);
    int order[$];
    int j;
    int t;
    for (int i = 0; i < n; i++) order.push_back(i);
    if ($urandom_range(0, 3) == 0) begin
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
    end
    foreach (order[i]) begin
      if (lossy && $urandom_range(0, 3) == 0) continue;
      send_header(fid, scr, order[i] == n - 1, order[i]);
      if (dup && $urandom_range(0, 4) == 0)
        send_header(fid, scr, order[i] == n - 1, order[i]);
    end
  endtask

  initial begin
    logic [FRAME_ID_W-1:0] cur [2];
    logic                  scr;
    int                    pick;
    int                    n;
    bit                    flooded;
    flooded = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed opener, screen 0: completion, repeat, full-size target
    send_header(8'h00, 1'b0, 1'b1, 8'h00);
    send_header(8'h00, 1'b0, 1'b1, 8'h00);
    send_header(8'h01, 1'b0, 1'b1, 8'hFF);
    send_header(8'h01, 1'b0, 1'b0, 8'h55);
    send_header(8'h01, 1'b0, 1'b0, 8'hAA);
    // retire a finished frame, then an unfinished one
    send_header(8'h02, 1'b0, 1'b1, 8'h00);
    send_header(8'h03, 1'b0, 1'b0, 8'h03);
    // resync jump, stale at the window edge, just past it
    send_header(8'h06, 1'b0, 1'b0, 8'h01);
    send_header(8'h03, 1'b0, 1'b1, 8'h07);
    send_header(8'h02, 1'b0, 1'b1, 8'h07);
    // screen 1: stale wrap, jump, completion, retire, stale, another jump
    send_header(8'hFF, 1'b1, 1'b1, 8'h00);
    send_header(8'h80, 1'b1, 1'b0, 8'h00);
    send_header(8'h81, 1'b1, 1'b1, 8'h00);
    send_header(8'h82, 1'b1, 1'b0, 8'h02);
    send_header(8'h7F, 1'b1, 1'b1, 8'h00);
    send_header(8'hFF, 1'b1, 1'b1, 8'hFF);
    send_header(8'hFF, 1'b1, 1'b0, 8'hFF);
    send_header(8'h00, 1'b1, 1'b1, 8'h7F);

    // random frame streams
    cur[0] = $urandom_range(0, 255);
    cur[1] = $urandom_range(0, 255);
    while (tx_sent < HEADER_COUNT) begin
      scr  = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      n    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      if (!flooded && tx_sent > 400) begin
        // drive one slot's count into saturation, then complete it
        for (int i = 0; i < FLOOD_LEN; i++)
          send_header(cur[scr], scr, 1'b0, $urandom_range(0, 255));
        send_header(cur[scr], scr, 1'b1, 8'hFF);
        cur[scr] = cur[scr] + 1'b1;
        flooded = 1'b1;
      end else if (pick < 60) begin
        send_frame(scr, cur[scr], n, $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
        cur[scr] = cur[scr] + 1'b1;
      end else if (pick < 72) begin
        // next frame shows up before the current one
        send_frame(scr, cur[scr] + 1'b1, n, $urandom_range(0, 3) == 0, 1'b0);
        send_frame(scr, cur[scr], $urandom_range(1, 8), $urandom_range(0, 3) == 0, 1'b0);
        cur[scr] = cur[scr] + 2'd2;
      end else if (pick < 82) begin
        send_header($urandom_range(0, 255), scr, $urandom_range(0, 1),
                    $urandom_range(0, 255));
      end else if (pick < 90) begin
        send_header(cur[scr] - $urandom_range(1, 6), scr, $urandom_range(0, 1),
                    $urandom_range(0, 255));
      end else if (pick < 95) begin
        cur[scr] = cur[scr] + $urandom_range(2, 6);
      end else begin
        cur[scr] = $urandom_range(0, 255);
      end
    end
    @(negedge clk) in_valid <= 1'b0;

    // drain and settle
    while (results_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("udp_frame_reassembly_tracker_unit: match");
    end else begin
      $display("udp_frame_reassembly_tracker_unit: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
design/ufrt_pkg.sv
design/ufrt_front.sv
design/ufrt_queue.sv
design/ufrt_back.sv
design/udp_frame_reassembly_tracker_unit.sv
verif/ufrt_placement_checker.sv
verif/tb.sv
